// ===== rtl/frcs_pkg.sv =====
// shared constants, item types and t-norm helpers for the fuzzy rank concordance sums
package frcs_pkg;

  localparam int SUM_WIDTH = 48;
  localparam int VAL_W     = 17;
  localparam int TERM_W    = VAL_W + 1;

  localparam logic [VAL_W-1:0]     Q_ONE   = VAL_W'(65536);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  // t-norm select codes
  localparam logic [1:0] MODE_MIN   = 2'd0;
  localparam logic [1:0] MODE_PROD  = 2'd1;
  localparam logic [1:0] MODE_LUK   = 2'd2;
  // unused code, behaves as minimum
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] x_forward;
    logic [VAL_W-1:0] x_backward;
    logic [VAL_W-1:0] y_forward;
    logic [VAL_W-1:0] y_backward;
    logic             last_pair;
  } in_item_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] concordance_sum;
    logic [SUM_WIDTH-1:0] discordance_sum;
    logic                 sum_saturated;
  } out_item_t;

  // values above one are clamped to one
  function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // selected t-norm of two clamped values, unused code acts as minimum
  function automatic logic [VAL_W-1:0] tnorm(input logic [1:0]       mode,
                                             input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] prod;
    logic [TERM_W-1:0]  sum;
    logic [VAL_W-1:0]   res;
    prod = a * b;
    sum  = TERM_W'(a) + TERM_W'(b);
    unique case (mode)
      MODE_PROD: res = prod[VAL_W+15:16];
      MODE_LUK:  res = (sum > TERM_W'(Q_ONE)) ? VAL_W'(sum - TERM_W'(Q_ONE)) : '0;
      default:   res = (a < b) ? a : b;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/frcs_channels.sv =====
// valid/ready channel interfaces for pair requests and sum results
interface frcs_in_if;
  import frcs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface frcs_out_if;
  import frcs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/frcs_pair_terms.sv =====
// concordant and discordant t-norm term sums of one index pair
module frcs_pair_terms (
  input  logic [1:0]                     mode,
  input  frcs_pkg::in_item_t             item,
  output logic [frcs_pkg::TERM_W-1:0]    conc,
  output logic [frcs_pkg::TERM_W-1:0]    disc
);
  import frcs_pkg::*;

  logic [VAL_W-1:0] xf, xb, yf, yb;
  logic [VAL_W-1:0] t_ff, t_bb, t_fb, t_bf;

  // clamp the four entries
  assign xf = clamp_one(item.x_forward);
  assign xb = clamp_one(item.x_backward);
  assign yf = clamp_one(item.y_forward);
  assign yb = clamp_one(item.y_backward);

  // four t-norms
  assign t_ff = tnorm(mode, xf, yf);
  assign t_bb = tnorm(mode, xb, yb);
  assign t_fb = tnorm(mode, xf, yb);
  assign t_bf = tnorm(mode, xb, yf);

  // pair sums
  assign conc = TERM_W'(t_ff) + TERM_W'(t_bb);
  assign disc = TERM_W'(t_fb) + TERM_W'(t_bf);

endmodule

// ===== rtl/fuzzy_rank_concordance_sums.sv =====
// fuzzy rank concordance sums: t-norm pair terms into saturating accumulators
// result: the last pair request passes the input and term registers, then its sums load the result register
// throughput: one pair request per cycle; input register, term register, accumulator
// only a pending result on a full, stalled output register holds the pipeline
// reset (rst, synchronous) clears valid bits, accumulators, flag and selects minimum
module fuzzy_rank_concordance_sums (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  frcs_in_if.sink    in_ch,
  frcs_out_if.source out_ch
);
  import frcs_pkg::*;

  logic [1:0]           tnorm_mode;
  logic                 s1_valid;
  in_item_t             s1_item;
  logic                 s2_valid;
  logic                 s2_last;
  logic [TERM_W-1:0]    s2_conc;
  logic [TERM_W-1:0]    s2_disc;
  logic [TERM_W-1:0]    conc_term;
  logic [TERM_W-1:0]    disc_term;
  logic [SUM_WIDTH-1:0] concordance_acc;
  logic [SUM_WIDTH-1:0] discordance_acc;
  logic                 saturation_flag;
  logic [SUM_WIDTH-1:0] concordance_acc_next;
  logic [SUM_WIDTH-1:0] discordance_acc_next;
  logic                 saturation_flag_next;
  logic [SUM_WIDTH:0]   conc_sum;
  logic [SUM_WIDTH:0]   disc_sum;
  logic                 conc_hit;
  logic                 disc_hit;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 stall;
  logic                 advance;
  logic                 emit;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tnorm_mode <= MODE_MIN;
    end else if (cfg_we) begin
      tnorm_mode <= cfg_wdata;
    end
  end

  // hold only when a result is due and the output register cannot take it
  assign stall   = s2_valid && s2_last && out_valid && !out_ch.ready;
  assign advance = !stall;
  assign emit    = s2_valid && s2_last && advance;

  assign in_ch.ready = advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_ch.valid) begin
      s1_item <= in_ch.payload;
    end
  end

  frcs_pair_terms u_terms (
    .mode (tnorm_mode),
    .item (s1_item),
    .conc (conc_term),
    .disc (disc_term)
  );

  // term register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_last <= s1_item.last_pair;
      s2_conc <= conc_term;
      s2_disc <= disc_term;
    end
  end

  // saturating accumulate
  always_comb begin
    conc_sum = {1'b0, concordance_acc} + (SUM_WIDTH+1)'(s2_conc);
    disc_sum = {1'b0, discordance_acc} + (SUM_WIDTH+1)'(s2_disc);
    conc_hit = conc_sum >= {1'b0, SUM_MAX};
    disc_hit = disc_sum >= {1'b0, SUM_MAX};
    concordance_acc_next = conc_hit ? SUM_MAX : conc_sum[SUM_WIDTH-1:0];
    discordance_acc_next = disc_hit ? SUM_MAX : disc_sum[SUM_WIDTH-1:0];
    saturation_flag_next = saturation_flag || conc_hit || disc_hit;
  end

  // accumulators clear after the last pair is emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      concordance_acc <= '0;
      discordance_acc <= '0;
      saturation_flag <= 1'b0;
    end else if (s2_valid && advance) begin
      if (s2_last) begin
        concordance_acc <= '0;
        discordance_acc <= '0;
        saturation_flag <= 1'b0;
      end else begin
        concordance_acc <= concordance_acc_next;
        discordance_acc <= discordance_acc_next;
        saturation_flag <= saturation_flag_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.concordance_sum <= concordance_acc_next;
      out_item.discordance_sum <= discordance_acc_next;
      out_item.sum_saturated   <= saturation_flag_next;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

// ===== tb/tb.sv =====
// testbench for the fuzzy rank concordance sums: directed pairs, random groups, stalls
module tb;
  import frcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          SETTLE      = 8;
  localparam int          MAX_SHOWN   = 10;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  frcs_in_if  pair_ch ();
  frcs_out_if sum_ch ();

  fuzzy_rank_concordance_sums uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pair_ch),
    .out_ch    (sum_ch)
  );

  // own copy of the block state for prediction
  logic [1:0]           tnorm_sel;
  logic [SUM_WIDTH-1:0] conc_model;
  logic [SUM_WIDTH-1:0] disc_model;
  logic                 sat_model;
  out_item_t            sums_due[$];

  int          mismatches;
  int unsigned cycles;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fuzzy_rank_concordance_sums verification failed");
      $finish;
    end
  end

  // entries above one count as one
  function automatic logic [VAL_W-1:0] limit_to_one(input logic [VAL_W-1:0] v);
    return (v > VAL_W'(65536)) ? VAL_W'(65536) : v;
  endfunction

  // fuzzy conjunction of two clamped entries under the selected t-norm
  function automatic logic [VAL_W-1:0] fuzzy_and(input logic [1:0]       sel,
                                                 input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] p;
    logic [VAL_W:0]     s;
    p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
    s = {1'b0, a} + {1'b0, b};
    case (sel)
      MODE_PROD: return VAL_W'(p >> 16);
      MODE_LUK:  return (s > (VAL_W+1)'(65536)) ? VAL_W'(s - (VAL_W+1)'(65536)) : '0;
      default:   return (a < b) ? a : b;
    endcase
  endfunction

  // saturating add, raises the model flag when the ceiling is reached
  function automatic logic [SUM_WIDTH-1:0] sat_sum(input logic [SUM_WIDTH-1:0] acc,
                                                   input logic [VAL_W:0]       t);
    logic [SUM_WIDTH:0] r;
    r = {1'b0, acc} + (SUM_WIDTH+1)'(t);
    if (r >= {1'b0, SUM_MAX}) begin
      sat_model = 1'b1;
      return SUM_MAX;
    end
    return r[SUM_WIDTH-1:0];
  endfunction

  // fold one accepted pair into the model, queue the sums on the last pair
  task automatic fold_pair(input in_item_t p);
    logic [VAL_W-1:0] xf, xb, yf, yb;
    logic [VAL_W:0]   conc, disc;
    out_item_t        r;
    xf = limit_to_one(p.x_forward);
    xb = limit_to_one(p.x_backward);
    yf = limit_to_one(p.y_forward);
    yb = limit_to_one(p.y_backward);
    conc = (VAL_W+1)'(fuzzy_and(tnorm_sel, xf, yf)) + (VAL_W+1)'(fuzzy_and(tnorm_sel, xb, yb));
    disc = (VAL_W+1)'(fuzzy_and(tnorm_sel, xf, yb)) + (VAL_W+1)'(fuzzy_and(tnorm_sel, xb, yf));
    conc_model = sat_sum(conc_model, conc);
    disc_model = sat_sum(disc_model, disc);
    if (p.last_pair) begin
      r.concordance_sum = conc_model;
      r.discordance_sum = disc_model;
      r.sum_saturated   = sat_model;
      sums_due.push_back(r);
      conc_model = '0;
      disc_model = '0;
      sat_model  = 1'b0;
    end
  endtask

  // one pair request, with random sender gaps
  task automatic send_pair(input in_item_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pair_ch.valid   <= 1'b1;
    pair_ch.payload <= p;
    do @(posedge clk); while (!pair_ch.ready);
    fold_pair(p);
  endtask

  task automatic release_pairs();
    @(negedge clk);
    pair_ch.valid <= 1'b0;
  endtask

  // wait for the block to drain, then write the t-norm select
  task automatic set_tnorm(input logic [1:0] sel);
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tnorm_sel = sel;
  endtask

  function automatic in_item_t make_pair(input int xf, input int xb, input int yf,
                                         input int yb, input bit last);
    in_item_t p;
    p.x_forward  = VAL_W'(xf);
    p.x_backward = VAL_W'(xb);
    p.y_forward  = VAL_W'(yf);
    p.y_backward = VAL_W'(yb);
    p.last_pair  = last;
    return p;
  endfunction

  // entry mix: corners, clamped region, full 17-bit range, mostly legal values
  function automatic logic [VAL_W-1:0] random_entry();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_W'(65536);
      2:       return VAL_W'($urandom_range(65537, 131071));
      3, 4:    return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // random groups of pairs, each closed by a last pair
  task automatic stream_groups(input int count, input int max_len);
    int       left;
    int       len;
    in_item_t p;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        p.x_forward  = random_entry();
        p.x_backward = random_entry();
        p.y_forward  = random_entry();
        p.y_backward = random_entry();
        p.last_pair  = (k == len - 1);
        send_pair(p);
      end
      left -= len;
    end
    release_pairs();
  endtask

  task automatic report_field(input string name, input logic [SUM_WIDTH-1:0] want,
                              input logic [SUM_WIDTH-1:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch in %s: expected %0d, got %0d", name, want, got);
  endtask

  // receiver: random stalls, plus a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      sum_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      sum_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && sum_ch.valid && sum_ch.ready) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: conc %0d disc %0d sat %0d",
                   sum_ch.payload.concordance_sum, sum_ch.payload.discordance_sum,
                   sum_ch.payload.sum_saturated);
      end else begin
        want = sums_due.pop_front();
        if (sum_ch.payload.concordance_sum !== want.concordance_sum)
          report_field("concordance_sum", want.concordance_sum,
                       sum_ch.payload.concordance_sum);
        if (sum_ch.payload.discordance_sum !== want.discordance_sum)
          report_field("discordance_sum", want.discordance_sum,
                       sum_ch.payload.discordance_sum);
        if (sum_ch.payload.sum_saturated !== want.sum_saturated)
          report_field("sum_saturated", SUM_WIDTH'(want.sum_saturated),
                       SUM_WIDTH'(sum_ch.payload.sum_saturated));
      end
    end
  end

  // corners of every t-norm, clamping, Lukasiewicz boundary, one-pair groups
  task automatic test_directed();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // minimum, the reset selection
    send_pair(make_pair(0, 0, 0, 0, 1));
    send_pair(make_pair(65536, 65536, 65536, 65536, 0));
    send_pair(make_pair(131071, 131071, 131071, 131071, 1));
    send_pair(make_pair(65536, 0, 0, 65536, 1));
    release_pairs();
    // product
    set_tnorm(MODE_PROD);
    send_pair(make_pair(65536, 65536, 65536, 65536, 0));
    send_pair(make_pair(32768, 32768, 1, 65535, 0));
    send_pair(make_pair(131071, 65537, 3, 5, 1));
    send_pair(make_pair(65535, 65535, 65535, 65535, 1));
    release_pairs();
    // lukasiewicz, sums exactly at one and just above
    set_tnorm(MODE_LUK);
    send_pair(make_pair(32768, 32768, 32768, 32768, 0));
    send_pair(make_pair(32769, 32768, 32768, 32767, 0));
    send_pair(make_pair(65536, 0, 65536, 131071, 1));
    send_pair(make_pair(1, 65536, 65536, 0, 1));
    release_pairs();
    // unused code falls back to minimum
    set_tnorm(MODE_SPARE);
    send_pair(make_pair(100, 200, 300, 50, 1));
    send_pair(make_pair(131071, 0, 65536, 65535, 1));
    release_pairs();
  endtask

  // random groups under all t-norms at one idling mix
  task automatic test_random_phase(input int src_pct, input int sink_pct, input int count);
    logic [1:0] sel;
    while (sums_due.size() != 0) @(posedge clk);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int m = 0; m < 4; m++) begin
      sel = 2'(m);
      set_tnorm(sel);
      stream_groups(count / 4, 12);
    end
  endtask

  // long receiver hold-off with short groups so the block backs up
  task automatic test_backpressure();
    set_tnorm(MODE_PROD);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_left = 150;
    stream_groups(60, 2);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = MODE_MIN;
    pair_ch.valid = 1'b0;
    pair_ch.payload = '0;
    sum_ch.ready  = 1'b0;
    tnorm_sel     = MODE_MIN;
    conc_model    = '0;
    disc_model    = '0;
    sat_model     = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phase(27, 67, 220);
    test_random_phase(67, 27, 220);
    test_random_phase(0, 0, 220);
    test_backpressure();

    // drain and finish
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("fuzzy_rank_concordance_sums verification clean");
    end else begin
      $display("fuzzy_rank_concordance_sums verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/frcs_pkg.sv
rtl/frcs_channels.sv
rtl/frcs_pair_terms.sv
rtl/fuzzy_rank_concordance_sums.sv
tb/tb.sv
